// File: rtl/slice_index_normalizer_macros.svh
// assertion macros for the slice index normalizer checker
`ifndef SLICE_INDEX_NORMALIZER_MACROS_SVH
`define SLICE_INDEX_NORMALIZER_MACROS_SVH

// clocked property, muted while reset is active
`define SIN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that also holds through reset
`define SIN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/sin_pkg.sv
`default_nettype none
package sin_pkg;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_INDEX = 2'd1,
        FAULT_RANGE = 2'd2
    } fault_t;

    localparam int DIV_STEPS = 64;

    localparam logic signed [63:0] OPEN_LO = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] OPEN_HI = {1'b0, {63{1'b1}}};

    typedef struct packed {
        logic               action;
        logic [62:0]        axis_len;
        logic signed [63:0] start_in;
        logic signed [63:0] finish_in;
        logic signed [63:0] step_in;
    } item_t;

    typedef struct packed {
        logic               drop_axis;
        logic [62:0]        first_pos;
        logic signed [63:0] stride_out;
        logic [62:0]        count_out;
        fault_t             fault;
    } result_t;

    // result fields known before the divide, plus the bypass flag
    typedef struct packed {
        logic        direct;
        logic        drop;
        logic [62:0] first;
        logic [63:0] stride;
        logic [62:0] count;
        fault_t      fault;
    } meta_t;

endpackage
`default_nettype wire

// File: rtl/sin_front.sv
`default_nettype none
module sin_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire sin_pkg::item_t in_item,
    output logic               out_valid,
    output logic [63:0]        out_num,
    output logic [63:0]        out_den,
    output sin_pkg::meta_t     out_meta
);
    import sin_pkg::*;

    // stage 1: input word
    item_t              item_reg;
    // stage 2: normalized ends
    meta_t              norm_meta_reg, norm_meta_next;
    logic signed [63:0] s_reg, s_next;
    logic signed [63:0] f_reg, f_next;
    logic [63:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    // stage 3: range size
    meta_t              size_meta_reg, size_meta_next;
    logic [63:0]        size_reg, size_next;
    logic [63:0]        mag3_reg;
    // stage 4: rounded-up numerator
    meta_t              num_meta_reg;
    logic [63:0]        num_reg, den_reg;
    logic [3:0]         vld_reg;

    logic [64:0]        s_wrap, f_wrap;
    logic               s_lt_len, f_lt_len, f_le_len, s_ok, f_ok;
    logic signed [63:0] len_s, size_s;

    always_comb
    begin
        len_s    = {1'b0, item_reg.axis_len};
        s_wrap   = {item_reg.start_in[63], item_reg.start_in} + {2'b00, item_reg.axis_len};
        f_wrap   = {item_reg.finish_in[63], item_reg.finish_in} + {2'b00, item_reg.axis_len};
        s_lt_len = item_reg.start_in[62:0] < item_reg.axis_len;
        f_lt_len = item_reg.finish_in[62:0] < item_reg.axis_len;
        f_le_len = item_reg.finish_in[62:0] <= item_reg.axis_len;
        norm_meta_next = '0;
        norm_meta_next.fault = FAULT_NONE;
        s_next   = item_reg.start_in;
        f_next   = item_reg.finish_in;
        neg_next = item_reg.step_in[63];
        mag_next = item_reg.step_in[63] ? (64'd0 - item_reg.step_in) : item_reg.step_in;
        s_ok     = 1'b1;
        f_ok     = 1'b1;
        if (!item_reg.action)
        begin
            // whole axis kept
            norm_meta_next.direct = 1'b1;
            norm_meta_next.stride = 64'd1;
            norm_meta_next.count  = item_reg.axis_len;
        end
        else if (item_reg.step_in == 64'sd0)
        begin
            norm_meta_next.direct = 1'b1;
            if (!item_reg.start_in[63] && s_lt_len)
            begin
                norm_meta_next.drop  = 1'b1;
                norm_meta_next.first = item_reg.start_in[62:0];
                norm_meta_next.count = 63'd1;
            end
            else if (item_reg.start_in[63] && !s_wrap[64])
            begin
                norm_meta_next.drop  = 1'b1;
                norm_meta_next.first = s_wrap[62:0];
                norm_meta_next.count = 63'd1;
            end
            else
            begin
                norm_meta_next.fault = FAULT_INDEX;
            end
        end
        else
        begin
            // start end
            if (!item_reg.start_in[63])
            begin
                s_ok = s_lt_len;
            end
            else if (!s_wrap[64])
            begin
                s_next = s_wrap[63:0];
            end
            else if (item_reg.start_in == OPEN_LO)
            begin
                s_next = item_reg.step_in[63] ? (len_s - 64'sd1) : 64'sd0;
            end
            else
            begin
                s_ok = 1'b0;
            end
            // finish end
            if (!item_reg.finish_in[63])
            begin
                if (item_reg.step_in[63] ? f_lt_len : f_le_len)
                begin
                    f_next = item_reg.finish_in;
                end
                else if (item_reg.finish_in == OPEN_HI)
                begin
                    f_next = item_reg.step_in[63] ? -64'sd1 : len_s;
                end
                else
                begin
                    f_ok = 1'b0;
                end
            end
            else if (!f_wrap[64])
            begin
                f_next = f_wrap[63:0];
            end
            else
            begin
                f_ok = 1'b0;
            end
            norm_meta_next.first  = s_next[62:0];
            norm_meta_next.stride = item_reg.step_in;
            if (!(s_ok && f_ok))
            begin
                norm_meta_next = '0;
                norm_meta_next.direct = 1'b1;
                norm_meta_next.fault  = FAULT_RANGE;
            end
        end
    end

    always_comb
    begin
        size_s         = neg_reg ? (s_reg - f_reg) : (f_reg - s_reg);
        size_next      = size_s;
        size_meta_next = norm_meta_reg;
        if (!norm_meta_reg.direct && (size_s[63] || size_s == 64'sd0))
        begin
            // empty range
            size_meta_next        = '0;
            size_meta_next.direct = 1'b1;
            size_meta_next.stride = 64'd1;
            size_meta_next.fault  = FAULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg      <= in_item;
            norm_meta_reg <= norm_meta_next;
            s_reg         <= s_next;
            f_reg         <= f_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            size_meta_reg <= size_meta_next;
            size_reg      <= size_next;
            mag3_reg      <= mag_reg;
            num_meta_reg  <= size_meta_reg;
            num_reg       <= size_reg + mag3_reg - 64'd1;
            den_reg       <= mag3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_meta  = num_meta_reg;

endmodule
`default_nettype wire

// File: rtl/sin_div.sv
`default_nettype none
module sin_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [63:0]    in_num,
    input  wire logic [63:0]    in_den,
    input  wire sin_pkg::meta_t in_meta,
    output logic                out_valid,
    output sin_pkg::result_t    out_res
);
    import sin_pkg::*;

    // restoring divide, one quotient bit per stage; quotient bits shift
    // into the numerator word as it empties
    logic [63:0]          rem_reg [DIV_STEPS];
    logic [63:0]          num_reg [DIV_STEPS];
    logic [63:0]          den_reg [DIV_STEPS];
    meta_t                meta_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [63:0] rem_i, num_i, den_i;
        meta_t       meta_i;
        logic [64:0] trial, diff;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rem_i  = '0;
            assign num_i  = in_num;
            assign den_i  = in_den;
            assign meta_i = in_meta;
        end
        else
        begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign num_i  = num_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign meta_i = meta_reg[k-1];
        end

        assign trial = {rem_i, num_i[63]};
        assign diff  = trial - {1'b0, den_i};
        assign ge    = !diff[64];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[63:0] : trial[63:0];
                num_reg[k]  <= {num_i[62:0], ge};
                den_reg[k]  <= den_i;
                meta_reg[k] <= meta_i;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_comb
    begin
        out_res.drop_axis  = meta_reg[DIV_STEPS-1].drop;
        out_res.first_pos  = meta_reg[DIV_STEPS-1].first;
        out_res.stride_out = meta_reg[DIV_STEPS-1].stride;
        out_res.fault      = meta_reg[DIV_STEPS-1].fault;
        out_res.count_out  = meta_reg[DIV_STEPS-1].direct ? meta_reg[DIV_STEPS-1].count
                                                          : num_reg[DIV_STEPS-1][62:0];
    end

    assign out_valid = vld_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: rtl/slice_index_normalizer.sv
// throughput: one word per cycle while no result word waits on res_stall;
// the pipeline is 4 normalize stages, a 64-stage one-bit-per-stage divider
// and one output register
// reset: asynchronous active low, clears all valid bits; payload is not reset
`default_nettype none
module slice_index_normalizer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire sin_pkg::item_t   item_data,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output sin_pkg::result_t      res_data
);
    import sin_pkg::*;

    // whole pipeline moves together; it holds only when the output word waits
    logic        en;
    logic        fr_valid;
    logic [63:0] fr_num, fr_den;
    meta_t       fr_meta;
    logic        dv_valid;
    result_t     dv_res;

    logic        res_valid_reg;
    result_t     res_data_reg;

    assign en         = !res_valid_reg || !res_stall;
    assign item_stall = !en;

    // range normalization and numerator for the rounded-up count
    sin_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .in_item   (item_data),
        .out_valid (fr_valid),
        .out_num   (fr_num),
        .out_den   (fr_den),
        .out_meta  (fr_meta)
    );

    // count = numerator / |step|, bypassed for direct results
    sin_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_meta   (fr_meta),
        .out_valid (dv_valid),
        .out_res   (dv_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_data_reg <= dv_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
`default_nettype wire

// File: rtl/sin_checker.sv
`default_nettype none
`include "slice_index_normalizer_macros.svh"
module sin_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_stall,
    input wire logic             res_valid,
    input wire logic             res_stall,
    input wire sin_pkg::result_t res_data
);
    import sin_pkg::*;

    // input side only holds back while a result word is waiting
    `SIN_ASSERT(a_stall_cause, item_stall |-> (res_valid && res_stall), "input stalled without cause")
    // a waiting result word holds
    `SIN_ASSERT(a_res_hold, (res_valid && res_stall) |=> (res_valid && $stable(res_data)), "result word changed while stalled")
    // faults carry no selection
    `SIN_ASSERT(a_fault_zero, (res_valid && res_data.fault != FAULT_NONE) |-> (res_data.count_out == 63'd0 && res_data.drop_axis == 1'b0), "fault with nonzero fields")
    // dropped axis selects exactly one element
    `SIN_ASSERT_ALWAYS(a_drop_one, (res_valid && res_data.drop_axis) |-> (res_data.count_out == 63'd1 && res_data.stride_out == 64'sd0), "dropped axis not single")

endmodule

bind slice_index_normalizer sin_checker u_sin_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
);
`default_nettype wire
